>>> src/mask_edge_point_centroid_defines.svh
// Assertion macros for the checker file.
`ifndef MASK_EDGE_POINT_CENTROID_DEFINES_SVH
`define MASK_EDGE_POINT_CENTROID_DEFINES_SVH

// Same-cycle implication, off during reset.
`define MEPC_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define MEPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, always checked (reset behavior).
`define MEPC_ASSERT_NEXT_ANY(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/mepc_pkg.sv
`default_nettype none
package mepc_pkg;

   localparam int COORD_W = 10;
   localparam int PIX_W   = 8;
   localparam int SUM_W   = 22;
   localparam int CNT_W   = 12;

   // coordinate window of the frame; compared on LIM_W bits (values up to 8191)
   localparam int LIM_W      = 13;
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   localparam int COL_SLOTS = 1 << COORD_W;

   localparam logic [PIX_W-1:0] FULL_VALUE  = PIX_W'(255);
   localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(4095);

   // divider steps: one quotient bit per cycle
   localparam int STEP_W = $clog2(SUM_W);

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

endpackage
`default_nettype wire

>>> src/mepc_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module mepc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  mepc_pkg::div_req_type      div_req,
   output logic                       div_done,
   output logic [mepc_pkg::SUM_W-1:0] div_quo
);
   import mepc_pkg::*;

   logic              run_ff, run_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  num_ff, num_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;

   logic [CNT_W:0]    shifted;
   logic [CNT_W:0]    rem_sub;
   logic              ge;

   assign shifted = {rem_ff, num_ff[SUM_W-1]};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign rem_sub = shifted - {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         run_in  = 1'b1;
         step_in = STEP_W'(SUM_W - 1);
         num_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
      end else if (run_ff) begin
         num_in  = {num_ff[SUM_W-2:0], 1'b0};
         quo_in  = {quo_ff[SUM_W-2:0], ge};
         rem_in  = ge ? rem_sub[CNT_W-1:0] : shifted[CNT_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
      step_ff <= step_in;
      num_ff  <= num_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   // last step completes at this edge; quotient is final afterwards
   assign div_done = run_ff && (step_ff == '0);
   assign div_quo  = quo_ff;

endmodule
`default_nettype wire

>>> src/mask_edge_point_centroid.sv
`default_nettype none
// Channel  Direction  Fields                                          Transfer
// req_     in         col_pos[10] row_pos[10] pixel[8] frame_end[1]   req_valid & req_ready
// rsp_     out        centroid_x[10] centroid_y[10] found[1]          rsp_valid & rsp_ready
//                     point_total[12]
//
// Cycles: one pixel per cycle inside a frame. The frame_end pixel closes the frame; the
//   column store is then swept clear, one entry per cycle, and req_ready stays low
//   meanwhile. Two dividers run under that sweep.
// Reset: synchronous; the same clear of the column store runs after reset.
// Stalls: a result waits in the rsp_ output register; a new frame may stream while it waits,
//   but its closing result is not produced until the previous one has been transferred.
module mask_edge_point_centroid (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mepc_pkg::COORD_W-1:0] req_col_pos,
   input  logic [mepc_pkg::COORD_W-1:0] req_row_pos,
   input  logic [mepc_pkg::PIX_W-1:0]   req_pixel,
   input  logic                         req_frame_end,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mepc_pkg::COORD_W-1:0] rsp_centroid_x,
   output logic [mepc_pkg::COORD_W-1:0] rsp_centroid_y,
   output logic                         rsp_found,
   output logic [mepc_pkg::CNT_W-1:0]   rsp_point_total
);
   import mepc_pkg::*;

   // column-seen store: 1 bit per column, one read and one write port
   logic column_seen_mem [COL_SLOTS];

   logic               req_acc;

   // clear sweep
   logic               clr_run_ff, clr_run_in;
   logic [COORD_W-1:0] clr_addr_ff, clr_addr_in;

   // stage 1: pixel whose column-seen bit has just been read
   logic               s1_valid_ff;
   logic [COORD_W-1:0] s1_col_ff;
   logic [COORD_W-1:0] s1_row_ff;
   logic [PIX_W-1:0]   s1_pix_ff;
   logic               s1_last_ff;
   logic               rd_seen_ff;
   logic               fwd_ff;

   // frame accumulators
   logic               row_hit_ff, row_hit_in;
   logic [SUM_W-1:0]   x_sum_ff, x_sum_in;
   logic [SUM_W-1:0]   y_sum_ff, y_sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // result handling
   logic               div_run_ff, div_run_in;
   logic               res_pend_ff, res_pend_in;
   logic               res_found_ff, res_found_in;
   logic [CNT_W-1:0]   res_total_ff, res_total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_W-1:0] rsp_y_ff, rsp_y_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [CNT_W-1:0]   rsp_total_ff, rsp_total_in;

   // stage 1 decision
   logic               in_window;
   logic               row_hit_now;
   logic               seen;
   logic               row_pt;
   logic               col_pt;
   logic               add1;
   logic               add2;
   logic [CNT_W-1:0]   cnt_mid;
   logic [1:0]         npts;
   logic [COORD_W:0]   x_add;
   logic [COORD_W:0]   y_add;
   logic [SUM_W-1:0]   x_next;
   logic [SUM_W-1:0]   y_next;
   logic [CNT_W-1:0]   cnt_next;
   logic               close_frame;

   // store write port
   logic               mem_we;
   logic [COORD_W-1:0] mem_wa;
   logic               mem_wd;

   // dividers
   div_req_type        div_x_req;
   div_req_type        div_y_req;
   logic               div_x_done;
   logic               div_y_done;
   logic [SUM_W-1:0]   div_x_quo;
   logic [SUM_W-1:0]   div_y_quo;
   logic               res_load;

   // hold off while sweeping, dividing, holding an unsent result, or closing a frame
   assign req_ready = !clr_run_ff && !div_run_ff && !res_pend_ff &&
                      !(s1_valid_ff && s1_last_ff);
   assign req_acc   = req_valid && req_ready;

   // ---- stage 1: judge the pixel ----
   assign in_window = ({{(LIM_W-COORD_W){1'b0}}, s1_col_ff} < LIM_W'(MAX_WIDTH)) &&
                      ({{(LIM_W-COORD_W){1'b0}}, s1_row_ff} < LIM_W'(MAX_HEIGHT));

   // column 0 opens a new row
   assign row_hit_now = (s1_col_ff == '0) ? 1'b0 : row_hit_ff;
   // previous pixel may have set the same column bit as this one was read
   assign seen   = rd_seen_ff || fwd_ff;
   assign row_pt = in_window && !row_hit_now && (s1_pix_ff != '0);
   assign col_pt = in_window && (s1_pix_ff == FULL_VALUE) && !seen;

   // points past the count limit are dropped, the marks are still set
   assign add1    = row_pt && (cnt_ff != COUNT_LIMIT);
   assign cnt_mid = cnt_ff + CNT_W'(add1);
   assign add2    = col_pt && (cnt_mid != COUNT_LIMIT);
   assign npts    = {1'b0, add1} + {1'b0, add2};

   always_comb begin
      case (npts)
         2'd1:    begin
            x_add = {1'b0, s1_col_ff};
            y_add = {1'b0, s1_row_ff};
         end
         2'd2:    begin
            x_add = {s1_col_ff, 1'b0};
            y_add = {s1_row_ff, 1'b0};
         end
         default: begin
            x_add = '0;
            y_add = '0;
         end
      endcase
   end

   assign x_next   = x_sum_ff + {{(SUM_W-COORD_W-1){1'b0}}, x_add};
   assign y_next   = y_sum_ff + {{(SUM_W-COORD_W-1){1'b0}}, y_add};
   assign cnt_next = cnt_ff + {{(CNT_W-2){1'b0}}, npts};

   assign close_frame = s1_valid_ff && s1_last_ff;

   // ---- column store write: sweep clears, stage 1 marks ----
   always_comb begin
      if (clr_run_ff) begin
         mem_we = 1'b1;
         mem_wa = clr_addr_ff;
         mem_wd = 1'b0;
      end else begin
         mem_we = s1_valid_ff && col_pt;
         mem_wa = s1_col_ff;
         mem_wd = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         column_seen_mem[mem_wa] <= mem_wd;
      end
      if (req_acc) begin
         rd_seen_ff <= column_seen_mem[req_col_pos];
         fwd_ff     <= mem_we && mem_wd && (mem_wa == req_col_pos);
      end
   end

   // ---- control and accumulators ----
   always_comb begin
      clr_run_in  = clr_run_ff;
      clr_addr_in = clr_addr_ff;
      row_hit_in  = row_hit_ff;
      x_sum_in    = x_sum_ff;
      y_sum_in    = y_sum_ff;
      cnt_in      = cnt_ff;

      if (clr_run_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == COORD_W'(COL_SLOTS - 1)) begin
            clr_run_in = 1'b0;
         end
      end

      if (s1_valid_ff) begin
         row_hit_in = row_pt || row_hit_now;
         x_sum_in   = x_next;
         y_sum_in   = y_next;
         cnt_in     = cnt_next;
      end

      if (close_frame) begin
         row_hit_in  = 1'b0;
         x_sum_in    = '0;
         y_sum_in    = '0;
         cnt_in      = '0;
         clr_run_in  = 1'b1;
         clr_addr_in = '0;
      end
   end

   // ---- closing divide ----
   assign div_x_req.start    = close_frame;
   assign div_x_req.dividend = x_next;
   assign div_x_req.divisor  = cnt_next;
   assign div_y_req.start    = close_frame;
   assign div_y_req.dividend = y_next;
   assign div_y_req.divisor  = cnt_next;

   mepc_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_x_req),
      .div_done (div_x_done),
      .div_quo  (div_x_quo)
   );

   mepc_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_y_req),
      .div_done (div_y_done),
      .div_quo  (div_y_quo)
   );

   assign res_load = res_pend_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      div_run_in   = div_run_ff;
      res_pend_in  = res_pend_ff;
      res_found_in = res_found_ff;
      res_total_in = res_total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_found_in = rsp_found_ff;
      rsp_total_in = rsp_total_ff;

      if (close_frame) begin
         div_run_in   = 1'b1;
         res_found_in = cnt_next != '0;
         res_total_in = cnt_next;
      end
      if (div_run_ff && div_x_done && div_y_done) begin
         div_run_in  = 1'b0;
         res_pend_in = 1'b1;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_load) begin
         res_pend_in  = 1'b0;
         rsp_valid_in = 1'b1;
         // empty frame: divide by zero result is discarded
         rsp_x_in     = res_found_ff ? div_x_quo[COORD_W-1:0] : '0;
         rsp_y_in     = res_found_ff ? div_y_quo[COORD_W-1:0] : '0;
         rsp_found_in = res_found_ff;
         rsp_total_in = res_total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_run_ff   <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         row_hit_ff   <= 1'b0;
         x_sum_ff     <= '0;
         y_sum_ff     <= '0;
         cnt_ff       <= '0;
         div_run_ff   <= 1'b0;
         res_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_run_ff   <= clr_run_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= req_acc;
         row_hit_ff   <= row_hit_in;
         x_sum_ff     <= x_sum_in;
         y_sum_ff     <= y_sum_in;
         cnt_ff       <= cnt_in;
         div_run_ff   <= div_run_in;
         res_pend_ff  <= res_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_acc) begin
         s1_col_ff  <= req_col_pos;
         s1_row_ff  <= req_row_pos;
         s1_pix_ff  <= req_pixel;
         s1_last_ff <= req_frame_end;
      end
      res_found_ff <= res_found_in;
      res_total_ff <= res_total_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_found_ff <= rsp_found_in;
      rsp_total_ff <= rsp_total_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_centroid_x  = rsp_x_ff;
   assign rsp_centroid_y  = rsp_y_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_point_total = rsp_total_ff;

endmodule
`default_nettype wire

>>> src/mepc_checker.sv
`default_nettype none
`include "mask_edge_point_centroid_defines.svh"
module mepc_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         req_frame_end,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [mepc_pkg::COORD_W-1:0] rsp_centroid_x,
   input wire logic [mepc_pkg::COORD_W-1:0] rsp_centroid_y,
   input wire logic                         rsp_found,
   input wire logic [mepc_pkg::CNT_W-1:0]   rsp_point_total
);
   import mepc_pkg::*;

   // stalled result holds
   `MEPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_centroid_x) && $stable(rsp_centroid_y) && $stable(rsp_found) && $stable(rsp_point_total), "rsp changed while stalled")

   // found flag agrees with the point count
   `MEPC_ASSERT_IMPL(a_found_total, clock, reset, rsp_valid, rsp_found == (rsp_point_total != '0), "found disagrees with point_total")

   // empty frame reports the origin
   `MEPC_ASSERT_IMPL(a_empty_zero, clock, reset, rsp_valid && !rsp_found, rsp_centroid_x == '0 && rsp_centroid_y == '0, "empty frame with nonzero centroid")

   // column store sweep follows reset
   `MEPC_ASSERT_NEXT_ANY(a_reset_sweep, clock, reset, !req_ready, "input open right after reset")

   // closing pixel stops intake while the frame is finished
   `MEPC_ASSERT_NEXT(a_close_stall, clock, reset, req_valid && req_ready && req_frame_end, !req_ready, "input open after frame end")

endmodule

bind mask_edge_point_centroid mepc_checker u_mepc_checker (.*);
`default_nettype wire

>>> test/tb_mask_edge_point_centroid.sv
`timescale 1ns / 1ps

module tb_mask_edge_point_centroid;

   localparam int CW = mepc_pkg::COORD_W;
   localparam int PW = mepc_pkg::PIX_W;
   localparam int NW = mepc_pkg::CNT_W;
   localparam int SW = mepc_pkg::SUM_W;

   // One closing transfer of a frame, as the result channel carries it.
   typedef struct packed {
      logic [CW-1:0] cx;
      logic [CW-1:0] cy;
      logic          found;
      logic [NW-1:0] total;
   } centroid_type;

   // Tracks the edge points of the current frame and queues the centroid
   // that each frame_end pixel must produce.
   class edge_centroid_model;
      bit            row_taken;
      bit            col_taken [mepc_pkg::COL_SLOTS];
      logic [SW-1:0] sum_x;
      logic [SW-1:0] sum_y;
      logic [NW-1:0] points;
      centroid_type  pending_centroids [$];
      int            mismatches;
      int            centroids_checked;
      int            saturated_frames;

      function void clear_frame();
         row_taken = 1'b0;
         foreach (col_taken[i])
            col_taken[i] = 1'b0;
         sum_x  = '0;
         sum_y  = '0;
         points = '0;
      endfunction

      function void add_point(logic [CW-1:0] x, logic [CW-1:0] y);
         if (points >= mepc_pkg::COUNT_LIMIT)
            return;
         sum_x  = sum_x + SW'(x);
         sum_y  = sum_y + SW'(y);
         points = points + 1'b1;
      endfunction

      function void take_pixel(logic [CW-1:0] col, logic [CW-1:0] row,
                               logic [PW-1:0] pix, logic last);
         centroid_type c;
         if (col == '0)
            row_taken = 1'b0;
         if (int'(col) < mepc_pkg::MAX_WIDTH && int'(row) < mepc_pkg::MAX_HEIGHT) begin
            if (!row_taken && pix != '0) begin
               row_taken = 1'b1;
               add_point(col, row);
            end
            if (pix == mepc_pkg::FULL_VALUE && !col_taken[col]) begin
               col_taken[col] = 1'b1;
               add_point(col, row);
            end
         end
         if (!last)
            return;
         if (points != '0) begin
            c.cx    = CW'(int'(sum_x) / int'(points));
            c.cy    = CW'(int'(sum_y) / int'(points));
            c.found = 1'b1;
         end else begin
            c.cx    = '0;
            c.cy    = '0;
            c.found = 1'b0;
         end
         c.total = points;
         if (points == mepc_pkg::COUNT_LIMIT)
            saturated_frames++;
         pending_centroids = {pending_centroids, c};
         clear_frame();
      endfunction

      task report(string what);
         mismatches++;
         if (mismatches <= 30)
            $display("MISMATCH @%0t: %s", $realtime, what);
      endtask

      task check_centroid(centroid_type got);
         centroid_type want;
         if (pending_centroids.size() == 0) begin
            report($sformatf("centroid transfer with none pending (%0d,%0d f=%0d n=%0d)",
                             got.cx, got.cy, got.found, got.total));
            return;
         end
         want = pending_centroids.pop_front();
         centroids_checked++;
         if (got.cx !== want.cx)
            report($sformatf("centroid_x %0d, expected %0d", got.cx, want.cx));
         if (got.cy !== want.cy)
            report($sformatf("centroid_y %0d, expected %0d", got.cy, want.cy));
         if (got.found !== want.found)
            report($sformatf("found %0d, expected %0d", got.found, want.found));
         if (got.total !== want.total)
            report($sformatf("point_total %0d, expected %0d", got.total, want.total));
      endtask
   endclass

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [CW-1:0] req_col_pos;
   logic [CW-1:0] req_row_pos;
   logic [PW-1:0] req_pixel;
   logic          req_frame_end;
   logic          rsp_valid;
   logic          rsp_ready;
   logic [CW-1:0] rsp_centroid_x;
   logic [CW-1:0] rsp_centroid_y;
   logic          rsp_found;
   logic [NW-1:0] rsp_point_total;

   edge_centroid_model centroid_calc;

   // calm: no idling on either side while set, gives back-to-back stretches
   bit calm;
   int pixels_sent;
   int frames_sent;

   mask_edge_point_centroid dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_col_pos     (req_col_pos),
      .req_row_pos     (req_row_pos),
      .req_pixel       (req_pixel),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_centroid_x  (rsp_centroid_x),
      .rsp_centroid_y  (rsp_centroid_y),
      .rsp_found       (rsp_found),
      .rsp_point_total (rsp_point_total)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop; the slowest legal run is well under a third of this.
   initial begin
      #(200_000_000);
      $display("TB_ERROR");
      $finish;
   end

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Mostly 0/255 as a cleaned mask gives, some in-between values too.
   function automatic logic [PW-1:0] pick_pixel(int fill);
      if ($urandom_range(0, 99) >= fill)
         return '0;
      if ($urandom_range(0, 4) == 0)
         return PW'($urandom_range(1, 254));
      return mepc_pkg::FULL_VALUE;
   endfunction

   // Entered and left at a falling edge. Valid stays up across back-to-back
   // pixels; the payload only moves after a transfer.
   task automatic send_pixel(logic [CW-1:0] col, logic [CW-1:0] row,
                             logic [PW-1:0] pix, logic last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_col_pos   = col;
      req_row_pos   = row;
      req_pixel     = pix;
      req_frame_end = last;
      req_valid     = 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      centroid_calc.take_pixel(col, row, pix, last);
      pixels_sent++;
      if (last)
         frames_sent++;
      @(negedge clock);
   endtask

   // A small raster window: each row opens at column 0 (sometimes not, which
   // leaves the row flag set), then jumps to a run of columns at a random
   // base so the column store sees repeats from row to row.
   task automatic send_frame();
      int  rows;
      int  cols;
      int  row_base;
      int  col_base;
      int  fill;
      int  n;
      int  first_c;
      bit  last;
      if ($urandom_range(0, 9) == 0) begin
         // noise: unordered pixels, any value
         n = $urandom_range(1, 10);
         for (int i = 0; i < n; i++)
            send_pixel(CW'($urandom), CW'($urandom), PW'($urandom), i == n - 1);
         return;
      end
      rows = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 5);
      cols = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 8);
      row_base = $urandom_range(0, 1024 - rows);
      col_base = $urandom_range(1, (cols > 1) ? 1025 - cols : 1023);
      fill = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : $urandom_range(20, 90);
      for (int r = 0; r < rows; r++) begin
         first_c = (cols > 1 && $urandom_range(0, 7) == 0) ? 1 : 0;
         for (int c = first_c; c < cols; c++) begin
            last = (r == rows - 1) && (c == cols - 1);
            send_pixel((c == 0) ? CW'(0) : CW'(col_base + c - 1), CW'(row_base + r),
                       pick_pixel(fill), last);
         end
      end
   endtask

   // Result side: random stalls drawn at the falling edge.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (stall_left == 0 && $urandom_range(0, 3) == 0)
            stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         centroid_calc.check_centroid('{rsp_centroid_x, rsp_centroid_y, rsp_found,
                                        rsp_point_total});
   end

   initial begin
      int random_start;
      centroid_calc = new();
      centroid_calc.clear_frame();
      calm          = 1'b0;
      pixels_sent   = 0;
      frames_sent   = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_col_pos   = '0;
      req_row_pos   = '0;
      req_pixel     = '0;
      req_frame_end = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // ready stays low through the post-reset clear of the column store;
      // the handshake wait covers it

      // --- directed ---
      // empty frame: nothing collected, found low
      send_pixel(CW'(0), CW'(0), '0, 1'b1);
      // single corner pixel at the top of both ranges: row and column point
      send_pixel(CW'(1023), CW'(1023), mepc_pkg::FULL_VALUE, 1'b1);
      // mid value counts for the row only; 255 at column 0 counts twice;
      // a column already seen adds nothing
      send_pixel(CW'(0), CW'(7), '0, 1'b0);
      send_pixel(CW'(1), CW'(7), '0, 1'b0);
      send_pixel(CW'(2), CW'(7), PW'(128), 1'b0);
      send_pixel(CW'(3), CW'(7), mepc_pkg::FULL_VALUE, 1'b0);
      send_pixel(CW'(0), CW'(8), mepc_pkg::FULL_VALUE, 1'b0);
      send_pixel(CW'(1), CW'(8), '0, 1'b0);
      send_pixel(CW'(3), CW'(8), mepc_pkg::FULL_VALUE, 1'b1);
      // the frame_end pixel itself is collected before the result
      send_pixel(CW'(0), CW'(512), '0, 1'b0);
      send_pixel(CW'(600), CW'(512), mepc_pkg::FULL_VALUE, 1'b1);
      // no column 0 between rows: the row flag carries over
      send_pixel(CW'(5), CW'(1), mepc_pkg::FULL_VALUE, 1'b0);
      send_pixel(CW'(6), CW'(2), PW'(200), 1'b1);
      // pixel value extremes and odd coordinates
      send_pixel(CW'(0), CW'(341), PW'(1), 1'b0);
      send_pixel(CW'(682), CW'(682), PW'(254), 1'b0);
      send_pixel(CW'(512), CW'(1023), mepc_pkg::FULL_VALUE, 1'b0);
      send_pixel(CW'(0), CW'(0), mepc_pkg::FULL_VALUE, 1'b1);

      // --- random frames ---
      random_start = pixels_sent;
      while (pixels_sent - random_start < 1080) begin
         calm = ($urandom_range(0, 3) == 0);
         send_frame();
      end
      calm      = 1'b0;
      req_valid = 1'b0;

      // drain, then allow for one more clearing sweep in case of a stray result
      while (centroid_calc.pending_centroids.size() > 0)
         @(posedge clock);
      repeat (1200) @(posedge clock);
      if (centroid_calc.pending_centroids.size() > 0)
         centroid_calc.report($sformatf("%0d centroids never transferred",
                                        centroid_calc.pending_centroids.size()));

      $display("Run: %0d pixels over %0d frames, %0d centroids checked, %0d at count limit",
               pixels_sent, frames_sent, centroid_calc.centroids_checked,
               centroid_calc.saturated_frames);
      $display("Mismatches: %0d", centroid_calc.mismatches);
      if (centroid_calc.mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

>>> mask_edge_point_centroid.f
+incdir+src
src/mepc_pkg.sv
src/mepc_div.sv
src/mask_edge_point_centroid.sv
src/mepc_checker.sv
test/tb_mask_edge_point_centroid.sv
